// ===== hdl/nhs_pkg.sv =====
package nhs_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRACTION_BITS = 16;
  localparam int G_BITS        = WORD_BITS - 1;
  // Bits of the cube root; its top bit is always clear.
  localparam int CROOT_BITS    = WORD_BITS - 1;
  // Quotient bits of G * 2^FRACTION_BITS / D.
  localparam int QUO_BITS      = G_BITS + FRACTION_BITS;
  localparam logic [G_BITS-1:0] G_RESET = G_BITS'(65536);
  // Reciprocal of three for an exact divide of a 32-bit non-negative value.
  localparam logic [32:0] RECIP3 = 33'h0AAAAAAAB;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [WORD_BITS:0]   wide_t;

  localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    word_t f_xx;
    word_t f_xy;
    word_t f_xz;
    word_t f_yx;
    word_t f_yy;
    word_t f_yz;
    word_t f_zx;
    word_t f_zy;
    word_t f_zz;
    word_t volume_ratio;
    word_t mean_pressure;
  } item_t;

  typedef struct packed {
    word_t s_xx;
    word_t s_yy;
    word_t s_zz;
    word_t s_xy;
    word_t s_yz;
    word_t s_xz;
    logic  bad_volume;
  } result_t;

  // Data that rides along the long root and divide chains.
  typedef struct packed {
    logic  bad;
    word_t j;
    word_t p;
    word_t bxx;
    word_t byy;
    word_t bzz;
    word_t bxy;
    word_t byz;
    word_t bxz;
    word_t ib3;
  } side_t;

  typedef struct packed {
    side_t sd;
    word_t c;
    word_t sq;
  } croot_t;

  typedef struct packed {
    side_t                sd;
    logic [G_BITS-1:0]    dd;
    logic [G_BITS-1:0]    r;
    logic [QUO_BITS-1:0]  q;
    logic [QUO_BITS-1:0]  n;
    logic                 dz;
    logic                 gz;
  } div_t;

  function automatic wide_t sx(input word_t a);
    return {a[WORD_BITS-1], a};
  endfunction

  // Fixed-point product, floored, saturated to the word range.
  function automatic word_t qmul(input wide_t a, input wide_t b);
    logic signed [2*WORD_BITS+1:0] pr;
    logic [2*WORD_BITS+1-FRACTION_BITS:0] sh;
    logic [WORD_BITS+2-FRACTION_BITS:0] top;
    pr  = a * b;
    sh  = pr[2*WORD_BITS+1:FRACTION_BITS];
    top = sh[2*WORD_BITS+1-FRACTION_BITS:WORD_BITS-1];
    if ((&top) || !(|top)) begin
      return sh[WORD_BITS-1:0];
    end else if (sh[$bits(sh)-1]) begin
      return WMIN;
    end else begin
      return WMAX;
    end
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    wide_t s;
    s = sx(a) + sx(b);
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? WMIN : WMAX;
    end
    return s[WORD_BITS-1:0];
  endfunction

endpackage

// ===== hdl/neo_hookean_stress.sv =====
// Incompressible neo-Hookean Cauchy stress, one material point per item, fully
// pipelined: an item can be accepted in every cycle while no result is stalled.
// The pipeline depth comes from the bit-per-stage cube root of the
// determinant (two multiply stages per root bit, 62 stages) and the
// bit-per-stage restoring divide that forms G / J^(5/3) (47 stages). When the
// result is stalled the whole pipeline holds, so item_stall follows
// result_stall while a result is waiting. All values are signed Q16.16 and
// saturate; a non-positive determinant gives bad_volume with zero stresses.
// shear_modulus may be written only while no item is in flight.
module neo_hookean_stress (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  nhs_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output nhs_pkg::result_t              result,
  input  logic                          shear_we,
  input  logic [nhs_pkg::G_BITS-1:0]    shear_data
);
  import nhs_pkg::*;

  localparam int NCR = 2 * CROOT_BITS;

  // One enable moves every stage; valid bits travel with the data.
  logic adv;
  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;

  // Shear modulus register.
  logic [G_BITS-1:0] shear_modulus;
  always_ff @(posedge clk) begin
    if (rst) begin
      shear_modulus <= G_RESET;
    end else if (shear_we) begin
      shear_modulus <= shear_data;
    end
  end

  // Stage 0: input register.
  item_t in_q;
  logic  v0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= item_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      in_q <= item;
    end
  end

  // Stage 1: the eighteen products of F times F-transpose.
  word_t prod [18];
  logic  v1, bad1;
  word_t j1, p1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      prod[0]  <= qmul(sx(in_q.f_xx), sx(in_q.f_xx));
      prod[1]  <= qmul(sx(in_q.f_xy), sx(in_q.f_xy));
      prod[2]  <= qmul(sx(in_q.f_xz), sx(in_q.f_xz));
      prod[3]  <= qmul(sx(in_q.f_yx), sx(in_q.f_yx));
      prod[4]  <= qmul(sx(in_q.f_yy), sx(in_q.f_yy));
      prod[5]  <= qmul(sx(in_q.f_yz), sx(in_q.f_yz));
      prod[6]  <= qmul(sx(in_q.f_zx), sx(in_q.f_zx));
      prod[7]  <= qmul(sx(in_q.f_zy), sx(in_q.f_zy));
      prod[8]  <= qmul(sx(in_q.f_zz), sx(in_q.f_zz));
      prod[9]  <= qmul(sx(in_q.f_xx), sx(in_q.f_yx));
      prod[10] <= qmul(sx(in_q.f_xy), sx(in_q.f_yy));
      prod[11] <= qmul(sx(in_q.f_xz), sx(in_q.f_yz));
      prod[12] <= qmul(sx(in_q.f_yx), sx(in_q.f_zx));
      prod[13] <= qmul(sx(in_q.f_yy), sx(in_q.f_zy));
      prod[14] <= qmul(sx(in_q.f_yz), sx(in_q.f_zz));
      prod[15] <= qmul(sx(in_q.f_xx), sx(in_q.f_zx));
      prod[16] <= qmul(sx(in_q.f_xy), sx(in_q.f_zy));
      prod[17] <= qmul(sx(in_q.f_xz), sx(in_q.f_zz));
      // The determinant must be strictly positive.
      bad1     <= in_q.volume_ratio[WORD_BITS-1] || (in_q.volume_ratio == '0);
      j1       <= in_q.volume_ratio;
      p1       <= in_q.mean_pressure;
    end
  end

  // Stage 2: the six components of b, each a saturated three-term sum.
  side_t s2_sd;
  logic  v2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sd.bad <= bad1;
      s2_sd.j   <= j1;
      s2_sd.p   <= p1;
      s2_sd.bxx <= sat_add(sat_add(prod[0], prod[1]), prod[2]);
      s2_sd.byy <= sat_add(sat_add(prod[3], prod[4]), prod[5]);
      s2_sd.bzz <= sat_add(sat_add(prod[6], prod[7]), prod[8]);
      s2_sd.bxy <= sat_add(sat_add(prod[9], prod[10]), prod[11]);
      s2_sd.byz <= sat_add(sat_add(prod[12], prod[13]), prod[14]);
      s2_sd.bxz <= sat_add(sat_add(prod[15], prod[16]), prod[17]);
      s2_sd.ib3 <= '0;
    end
  end

  // Stage 3: the trace of b.
  side_t s3_sd;
  word_t tr;
  logic  v3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sd <= s2_sd;
      tr    <= sat_add(sat_add(s2_sd.bxx, s2_sd.byy), s2_sd.bzz);
    end
  end

  // Stage 4: one third of the trace, by the exact reciprocal of three. The
  // trace is a sum of squares and never negative.
  side_t        s4_sd;
  logic         v4;
  logic [65:0]  tr3;
  assign tr3 = {33'b0, 1'b0, tr[WORD_BITS-1:0]} * {33'b0, RECIP3};
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_sd.bad <= s3_sd.bad;
      s4_sd.j   <= s3_sd.j;
      s4_sd.p   <= s3_sd.p;
      s4_sd.bxx <= s3_sd.bxx;
      s4_sd.byy <= s3_sd.byy;
      s4_sd.bzz <= s3_sd.bzz;
      s4_sd.bxy <= s3_sd.bxy;
      s4_sd.byz <= s3_sd.byz;
      s4_sd.bxz <= s3_sd.bxz;
      s4_sd.ib3 <= word_t'(tr3[64:33]);
    end
  end

  // Cube root of J, one bit per stage pair: the first stage squares the
  // candidate, the second cubes it and keeps the bit when the cube fits.
  croot_t cr    [NCR];
  logic   cv    [NCR];
  croot_t cr_in [CROOT_BITS];
  logic   cv_in [CROOT_BITS];

  for (genvar k = 0; k < CROOT_BITS; k++) begin : g_croot
    word_t bitv, cand_a, cand_b, cube;
    assign bitv   = word_t'(1) << (CROOT_BITS - 1 - k);
    assign cand_a = cr_in[k].c | bitv;
    assign cand_b = cr[2*k].c | bitv;
    assign cube   = qmul(sx(cr[2*k].sq), sx(cand_b));

    if (k == 0) begin : g_first
      assign cr_in[k] = '{sd: s4_sd, c: '0, sq: '0};
      assign cv_in[k] = v4;
    end else begin : g_next
      assign cr_in[k] = cr[2*k-1];
      assign cv_in[k] = cv[2*k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[2*k]   <= 1'b0;
        cv[2*k+1] <= 1'b0;
      end else if (adv) begin
        cv[2*k]   <= cv_in[k];
        cv[2*k+1] <= cv[2*k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cr[2*k].sd   <= cr_in[k].sd;
        cr[2*k].c    <= cr_in[k].c;
        cr[2*k].sq   <= qmul(sx(cand_a), sx(cand_a));
        cr[2*k+1].sd <= cr[2*k].sd;
        cr[2*k+1].sq <= cr[2*k].sq;
        cr[2*k+1].c  <= (cube <= cr[2*k].sd.j) ? cand_b : cr[2*k].c;
      end
    end
  end

  // D = J * c^2 in two multiply stages.
  side_t ds_sd;
  word_t ds_sq;
  logic  vds;
  div_t  dv_in;
  logic  vdi;
  word_t dval;
  assign dval = qmul(sx(ds_sd.j), sx(ds_sq));
  always_ff @(posedge clk) begin
    if (rst) begin
      vds <= 1'b0;
      vdi <= 1'b0;
    end else if (adv) begin
      vds <= cv[NCR-1];
      vdi <= vds;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ds_sd    <= cr[NCR-1].sd;
      ds_sq    <= qmul(sx(cr[NCR-1].c), sx(cr[NCR-1].c));
      dv_in.sd <= ds_sd;
      // J is positive and c^2 is not negative, so D is never negative.
      dv_in.dd <= dval[G_BITS-1:0];
      dv_in.r  <= '0;
      dv_in.q  <= '0;
      dv_in.n  <= {shear_modulus, {FRACTION_BITS{1'b0}}};
      dv_in.dz <= (dval == '0);
      dv_in.gz <= (shear_modulus == '0);
    end
  end

  // Restoring divide G * 2^FRACTION_BITS / D, one quotient bit per stage.
  div_t dv [QUO_BITS];
  logic dvv [QUO_BITS];

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
    div_t             prev;
    logic             pv;
    logic [G_BITS:0]  rs, diff;
    logic             ge;
    if (i == 0) begin : g_first
      assign prev = dv_in;
      assign pv   = vdi;
    end else begin : g_next
      assign prev = dv[i-1];
      assign pv   = dvv[i-1];
    end
    assign rs   = {prev.r, prev.n[QUO_BITS-1-i]};
    assign ge   = rs >= {1'b0, prev.dd};
    assign diff = rs - {1'b0, prev.dd};

    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[i] <= 1'b0;
      end else if (adv) begin
        dvv[i] <= pv;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv[i].sd <= prev.sd;
        dv[i].dd <= prev.dd;
        dv[i].r  <= ge ? diff[G_BITS-1:0] : rs[G_BITS-1:0];
        dv[i].q  <= {prev.q[QUO_BITS-2:0], ge};
        dv[i].n  <= prev.n;
        dv[i].dz <= prev.dz;
        dv[i].gz <= prev.gz;
      end
    end
  end

  // Scale muJ with saturation and the vanishing-power case.
  side_t mu_sd;
  word_t mu;
  logic  vmu;
  div_t  dl;
  assign dl = dv[QUO_BITS-1];
  always_ff @(posedge clk) begin
    if (rst) begin
      vmu <= 1'b0;
    end else if (adv) begin
      vmu <= dvv[QUO_BITS-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      mu_sd <= dl.sd;
      if (dl.dz) begin
        mu <= dl.gz ? '0 : WMAX;
      end else if (|dl.q[QUO_BITS-1:WORD_BITS-1]) begin
        mu <= WMAX;
      end else begin
        mu <= word_t'(dl.q[WORD_BITS-1:0]);
      end
    end
  end

  // Stress products; the deviatoric difference is kept one bit wider.
  word_t m [6];
  side_t m_sd;
  logic  vm;
  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (adv) begin
      vm <= vmu;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_sd <= mu_sd;
      m[0] <= qmul(sx(mu), sx(mu_sd.bxx) - sx(mu_sd.ib3));
      m[1] <= qmul(sx(mu), sx(mu_sd.byy) - sx(mu_sd.ib3));
      m[2] <= qmul(sx(mu), sx(mu_sd.bzz) - sx(mu_sd.ib3));
      m[3] <= qmul(sx(mu), sx(mu_sd.bxy));
      m[4] <= qmul(sx(mu), sx(mu_sd.byz));
      m[5] <= qmul(sx(mu), sx(mu_sd.bxz));
    end
  end

  // Output register: pressure on the normals, or zeros for a bad volume.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= vm;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      result.bad_volume <= m_sd.bad;
      if (m_sd.bad) begin
        result.s_xx <= '0;
        result.s_yy <= '0;
        result.s_zz <= '0;
        result.s_xy <= '0;
        result.s_yz <= '0;
        result.s_xz <= '0;
      end else begin
        result.s_xx <= sat_add(m[0], m_sd.p);
        result.s_yy <= sat_add(m[1], m_sd.p);
        result.s_zz <= sat_add(m[2], m_sd.p);
        result.s_xy <= m[3];
        result.s_yz <= m[4];
        result.s_xz <= m[5];
      end
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.bad_volume |->
      result.s_xx == '0 && result.s_yy == '0 && result.s_zz == '0 &&
      result.s_xy == '0 && result.s_yz == '0 && result.s_xz == '0)
    else $error("bad volume result carries nonzero stress");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    dvv[QUO_BITS-1] && dl.dd != '0 |-> dl.r < dl.dd)
    else $error("divider remainder not below divisor");

  a_third_pos: assert property (@(posedge clk) disable iff (rst)
    v4 |-> !s4_sd.ib3[WORD_BITS-1])
    else $error("one third of trace is negative");

endmodule

// ===== test/nhs_checker.sv =====
module nhs_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  logic                       item_stall,
  input  nhs_pkg::item_t             item,
  input  logic                       result_valid,
  input  logic                       result_stall,
  input  nhs_pkg::result_t           result,
  input  logic                       shear_we,
  input  logic [nhs_pkg::G_BITS-1:0] shear_data,
  output int                         fail_count,
  output int                         pending
);
  import nhs_pkg::*;

  localparam longint LMAX = 64'sd2147483647;
  localparam longint LMIN = -64'sd2147483648;

  logic [G_BITS-1:0] modulus;
  result_t stress_q[$];

  function automatic longint clamp_word(input longint v);
    if (v > LMAX) return LMAX;
    if (v < LMIN) return LMIN;
    return v;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    longint pr;
    pr = a * b;
    return clamp_word(pr >>> FRACTION_BITS);
  endfunction

  function automatic longint fx_add(input longint a, input longint b);
    return clamp_word(a + b);
  endfunction

  function automatic longint gram(input longint a0, input longint a1, input longint a2,
                                  input longint b0, input longint b1, input longint b2);
    return fx_add(fx_add(fx_mul(a0, b0), fx_mul(a1, b1)), fx_mul(a2, b2));
  endfunction

  function automatic result_t stress_of(input item_t it, input logic [G_BITS-1:0] gmod);
    result_t r;
    longint j, p, bxx, byy, bzz, bxy, byz, bxz, ib3, c, cand, d, g, muj;
    longint fx, fy, fz, gx, gy, gz, hx, hy, hz;
    r = '0;
    j = longint'(it.volume_ratio);
    p = longint'(it.mean_pressure);
    if (j <= 0) begin
      r.bad_volume = 1'b1;
      return r;
    end
    fx = it.f_xx; fy = it.f_xy; fz = it.f_xz;
    gx = it.f_yx; gy = it.f_yy; gz = it.f_yz;
    hx = it.f_zx; hy = it.f_zy; hz = it.f_zz;
    bxx = gram(fx, fy, fz, fx, fy, fz);
    byy = gram(gx, gy, gz, gx, gy, gz);
    bzz = gram(hx, hy, hz, hx, hy, hz);
    bxy = gram(fx, fy, fz, gx, gy, gz);
    byz = gram(gx, gy, gz, hx, hy, hz);
    bxz = gram(fx, fy, fz, hx, hy, hz);
    ib3 = fx_add(fx_add(bxx, byy), bzz) / 3;
    // Cube root of the determinant, one bit at a time from the top.
    c = 0;
    for (int b = WORD_BITS - 2; b >= 0; b--) begin
      cand = c | (64'sd1 << b);
      if (fx_mul(fx_mul(cand, cand), cand) <= j) c = cand;
    end
    d = fx_mul(j, fx_mul(c, c));
    g = longint'(gmod);
    if (d == 0) muj = (g == 0) ? 0 : LMAX;
    else muj = clamp_word((g <<< FRACTION_BITS) / d);
    r.s_xx = word_t'(fx_add(fx_mul(muj, bxx - ib3), p));
    r.s_yy = word_t'(fx_add(fx_mul(muj, byy - ib3), p));
    r.s_zz = word_t'(fx_add(fx_mul(muj, bzz - ib3), p));
    r.s_xy = word_t'(fx_mul(muj, bxy));
    r.s_yz = word_t'(fx_mul(muj, byz));
    r.s_xz = word_t'(fx_mul(muj, bxz));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    fail_count = fail_count + 1;
  endtask

  initial begin
    fail_count = 0;
  end

  assign pending = stress_q.size();

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      modulus = G_RESET;
      stress_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (stress_q.size() == 0) begin
          report_mismatch("result with nothing expected", 0, 0);
        end else begin
          want = stress_q.pop_front();
          if (result.s_xx != want.s_xx) report_mismatch("s_xx", result.s_xx, want.s_xx);
          if (result.s_yy != want.s_yy) report_mismatch("s_yy", result.s_yy, want.s_yy);
          if (result.s_zz != want.s_zz) report_mismatch("s_zz", result.s_zz, want.s_zz);
          if (result.s_xy != want.s_xy) report_mismatch("s_xy", result.s_xy, want.s_xy);
          if (result.s_yz != want.s_yz) report_mismatch("s_yz", result.s_yz, want.s_yz);
          if (result.s_xz != want.s_xz) report_mismatch("s_xz", result.s_xz, want.s_xz);
          if (result.bad_volume != want.bad_volume) begin
            report_mismatch("bad_volume", result.bad_volume, want.bad_volume);
          end
        end
      end
      if (item_valid && !item_stall) stress_q.push_back(stress_of(item, modulus));
      if (shear_we) modulus = shear_data;
    end
  end
endmodule

// ===== test/tb.sv =====
module tb;
  import nhs_pkg::*;

  // This margin covers draining the pipeline.
  localparam int DRAIN_CYCLES = 140;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic shear_we = 1'b0;
  logic [G_BITS-1:0] shear_data = '0;

  int fail_count;
  int pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  neo_hookean_stress uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .shear_we(shear_we), .shear_data(shear_data)
  );

  nhs_checker chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .shear_we(shear_we), .shear_data(shear_data),
    .fail_count(fail_count), .pending(pending)
  );

  // The receiver stalls at random, and during a long hold-off it stalls
  // continuously so that the pipeline fills and pushes back on the sender.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
    result_stall <= (hold_left > 1) || hold_go || ($urandom_range(99) < rx_idle_pct);
  end

  // The watchdog ends the run if no item moves on either channel for too long.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Offer one item and hold it until it is accepted, then idle at random,
  // with a fresh draw before each idle cycle.
  task automatic send_point(input item_t pt);
    item_valid <= 1'b1;
    item <= pt;
    do @(posedge clk); while (item_stall);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop offering items until every expected result has come back.
  task automatic drain_pipeline();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [G_BITS-1:0] g);
    shear_we <= 1'b1;
    shear_data <= g;
    @(posedge clk);
    shear_we <= 1'b0;
  endtask

  function automatic word_t near_value(input int center, input int spread);
    return word_t'(center + $urandom_range(0, 2 * spread) - spread);
  endfunction

  // A plausible deformation: F close to the identity, J close to one, and a
  // moderate pressure. Most random items look like this.
  function automatic item_t plausible_point();
    item_t pt;
    pt.f_xx = near_value(65536, 20000);
    pt.f_xy = near_value(0, 20000);
    pt.f_xz = near_value(0, 20000);
    pt.f_yx = near_value(0, 20000);
    pt.f_yy = near_value(65536, 20000);
    pt.f_yz = near_value(0, 20000);
    pt.f_zx = near_value(0, 20000);
    pt.f_zy = near_value(0, 20000);
    pt.f_zz = near_value(65536, 20000);
    pt.volume_ratio = near_value(65536, 30000);
    pt.mean_pressure = near_value(0, 1 << 20);
    return pt;
  endfunction

  function automatic item_t random_point();
    item_t pt;
    int kind;
    kind = $urandom_range(99);
    if (kind < 60) begin
      pt = plausible_point();
    end else begin
      pt = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom};
      // Keep some full-range items but force the determinant positive on
      // most of them, so that the stress path sees wild values too.
      if (kind < 85) pt.volume_ratio = word_t'($urandom_range(1, 32'h7fffffff));
      else if (kind < 92) pt.volume_ratio = -word_t'($urandom_range(0, 32'h7fffffff));
    end
    return pt;
  endfunction

  function automatic item_t uniform_point(input word_t f, input word_t j, input word_t p);
    return {f, f, f, f, f, f, f, f, f, j, p};
  endfunction

  initial begin
    item_t pt;
    logic [G_BITS-1:0] moduli [6];
    moduli[0] = '0;
    moduli[1] = {G_BITS{1'b1}};
    moduli[2] = G_BITS'($urandom);
    moduli[3] = G_BITS'(3 * 65536);
    moduli[4] = G_BITS'($urandom_range(1, 4096));
    moduli[5] = G_RESET;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items under the reset modulus, no idling on either side.
    pt = '0;
    pt.f_xx = 65536; pt.f_yy = 65536; pt.f_zz = 65536; pt.volume_ratio = 65536;
    send_point(pt);
    pt.mean_pressure = WMAX;
    send_point(pt);
    pt.mean_pressure = WMIN;
    send_point(pt);
    // A non-positive determinant: zero, minus one, and the most negative word.
    send_point(uniform_point(65536, 0, 12345));
    send_point(uniform_point(65536, -1, 12345));
    send_point(uniform_point(WMAX, WMIN, WMAX));
    // Extremes of every field, which saturate each stage.
    send_point(uniform_point(WMAX, WMAX, WMAX));
    send_point(uniform_point(WMIN, WMAX, WMIN));
    send_point(uniform_point(WMIN, 1, WMAX));
    send_point(uniform_point(-1, WMAX, -1));
    send_point(uniform_point(0, WMAX, 0));
    // Tiny determinants; the smallest makes the volume power vanish.
    send_point(uniform_point(65536, 1, 0));
    send_point(uniform_point(65536, 255, 0));
    send_point(uniform_point(65536, 4096, 0));
    send_point(uniform_point(32768, 8192, -65536));
    // Pure shear, a stretch and a pure rotation.
    pt = '0;
    pt.f_xx = 65536; pt.f_xy = 32768; pt.f_yy = 65536; pt.f_zz = 65536;
    pt.volume_ratio = 65536;
    send_point(pt);
    pt = '0;
    pt.f_xx = 131072; pt.f_yy = 46341; pt.f_zz = 46341; pt.volume_ratio = 65536;
    send_point(pt);
    pt = '0;
    pt.f_yx = 65536; pt.f_zy = 65536; pt.f_xz = 65536; pt.volume_ratio = 65536;
    send_point(pt);
    repeat (4) send_point(random_point());
    drain_pipeline();

    // Six random phases, each with its own modulus; idling changes every
    // two phases: sender-light and receiver-heavy, the reverse, then none.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        tx_idle_pct = 31;
        rx_idle_pct = 85;
      end else if (ph < 4) begin
        tx_idle_pct = 85;
        rx_idle_pct = 31;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      repeat (DRAIN_CYCLES) @(posedge clk);
      write_modulus(moduli[ph]);
      for (int n = 0; n < 305; n++) begin
        // Partway through the last phase the receiver holds off for a long
        // stretch while the sender keeps offering items.
        if (ph == 5 && n == 40) begin
          hold_go <= 1'b1;
          send_point(random_point());
          hold_go <= 1'b0;
        end else begin
          send_point(random_point());
        end
      end
      drain_pipeline();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
